// ===== rtl/tsa_pkg.sv =====
package tsa_pkg;

	localparam int MODE_W   = 2;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 6;
	localparam int CPU_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_MAP   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UNMAP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CPU_INDEX   = 1'd1;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [ADDR_W-1:0]   mapped_addr;
		logic                flush_needed;
		logic [ADDR_W-1:0]   flush_addr;
	} rsp_t;

endpackage

// ===== rtl/tsa_if.sv =====
interface tsa_req_if;
	import tsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] virt_addr;

	modport source (output valid, output mode, output virt_addr, input ready);
	modport sink   (input valid, input mode, input virt_addr, output ready);
endinterface

interface tsa_rsp_if;
	import tsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [ADDR_W-1:0]   mapped_addr;
	logic                flush_needed;
	logic [ADDR_W-1:0]   flush_addr;

	modport source (output valid, output status, output slot, output mapped_addr,
		output flush_needed, output flush_addr, input ready);
	modport sink   (input valid, input status, input slot, input mapped_addr,
		input flush_needed, input flush_addr, output ready);
endinterface

// ===== rtl/transient_slot_allocator_top.sv =====
// Transient slot allocator.
// req channel: mode (map, unmap, flush done advice) and virt_addr (unmap only).
// rsp channel: exactly one result per request: status, slot, mapped_addr,
// flush_needed and flush_addr.
// cfg port: write window_base (index 0) or cpu_index (index 1) while idle.
// Pipeline: the first three stages reduce the unmap address to a slot
// number, the fourth stage holds the free/released masks and forms the
// result in the output register.
// Throughput: one request per cycle while the receiver takes results, set
// by the mask update in the fourth stage.
// Reset: every slot free, no slot released, both registers zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req.ready drops; it rises again in the cycle the result is taken.
module transient_slot_allocator_top #(
	parameter int SLOTS      = 64,
	parameter int PAGE_SHIFT = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	tsa_req_if.sink                           req,
	tsa_rsp_if.source                         rsp
);
	import tsa_pkg::*;

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int EB    = ADDR_W - PAGE_SHIFT;
	localparam int SUMW  = $clog2(EB * (SLOTS - 1) + 1);
	localparam logic [SUMW-1:0] RECIP = SUMW'((1 << SUMW) / SLOTS);
	localparam logic [SUMW-1:0] SLOTS_V = SUMW'(SLOTS);

	// configuration
	logic [ADDR_W-1:0] window_base_q;
	logic [CPU_W-1:0]  cpu_index_q;
	logic [ADDR_W-1:0] grp_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q <= '0;
			cpu_index_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WINDOW_BASE: window_base_q <= cfg_wdata[ADDR_W-1:0];
				CFG_CPU_INDEX:   cpu_index_q   <= cfg_wdata[CPU_W-1:0];
				default: ;
			endcase
		end
	end

	// page index of slot 0 of this processor's group, relative to window_base
	logic [ADDR_W-1:0] grp_entry;
	assign grp_entry = ADDR_W'(cpu_index_q) * ADDR_W'(SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_base_q <= '0;
		end else begin
			grp_base_q <= window_base_q + (grp_entry << PAGE_SHIFT);
		end
	end

	// pipeline control
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [MODE_W-1:0] mode_s1, mode_s2, mode_s3, mode_s4;
	logic [ADDR_W-1:0] va_s1;
	logic [SUMW-1:0]   sum_s2, sum_s3;
	logic [SUMW-1:0]   q_s3;
	logic [SW-1:0]     slot_s4;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			rsp_valid_q <= v_s4;
		end
	end

	// stage 1: page number of the unmap address, folded to a small sum
	// of (2^i mod SLOTS) weights
	logic [ADDR_W-1:0] diff;
	logic [EB-1:0]     entry;
	logic [SUMW-1:0]   fold_sum;

	assign diff  = va_s1 - window_base_q;
	assign entry = diff[ADDR_W-1:PAGE_SHIFT];

	always_comb begin
		fold_sum = '0;
		for (int i = 0; i < EB; i++) begin
			if (entry[i])
				fold_sum = fold_sum + SUMW'((1 << i) % SLOTS);
		end
	end

	// stage 2: quotient estimate by reciprocal, low by at most one
	logic [2*SUMW-1:0] prod;
	assign prod = (2*SUMW)'(sum_s2) * (2*SUMW)'(RECIP);

	// stage 3: remainder with one correction
	logic [SUMW-1:0] rem;
	logic [SUMW-1:0] rem_fix;
	always_comb begin
		rem     = sum_s3 - SUMW'(q_s3 * SLOTS_V);
		rem_fix = (rem >= SLOTS_V) ? (rem - SLOTS_V) : rem;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= req.mode;
			va_s1   <= req.virt_addr;
			mode_s2 <= mode_s1;
			sum_s2  <= fold_sum;
			mode_s3 <= mode_s2;
			sum_s3  <= sum_s2;
			q_s3    <= prod[2*SUMW-1:SUMW];
			mode_s4 <= mode_s3;
			slot_s4 <= rem_fix[SW-1:0];
		end
	end

	// stage 4: masks and result
	logic [SLOTS-1:0] free_q, rel_q;
	logic [SLOTS-1:0] free_d, rel_d;
	logic             f_found, r_found;
	logic [SW-1:0]    f_idx, r_idx;
	logic [SW-1:0]    pick_idx;
	logic [ADDR_W-1:0] pick_addr;
	rsp_t             rsp_d;

	always_comb begin
		f_found = 1'b0;
		r_found = 1'b0;
		f_idx   = '0;
		r_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				f_found = 1'b1;
				f_idx   = SW'(i);
			end
			if (rel_q[i]) begin
				r_found = 1'b1;
				r_idx   = SW'(i);
			end
		end
	end

	assign pick_idx  = f_found ? f_idx : r_idx;
	assign pick_addr = grp_base_q + (ADDR_W'(pick_idx) << PAGE_SHIFT);

	always_comb begin
		free_d = free_q;
		rel_d  = rel_q;
		rsp_d  = '0;
		unique case (mode_s4)
			MODE_MAP: begin
				priority if (f_found) begin
					free_d[f_idx]     = 1'b0;
					rsp_d.slot        = SLOT_W'(f_idx);
					rsp_d.mapped_addr = pick_addr;
				end else if (r_found) begin
					// reclaim: the stale translation must be flushed
					rel_d[r_idx]       = 1'b0;
					rsp_d.slot         = SLOT_W'(r_idx);
					rsp_d.mapped_addr  = pick_addr;
					rsp_d.flush_needed = 1'b1;
					rsp_d.flush_addr   = pick_addr;
				end else begin
					rsp_d.status = ST_NO_SLOT;
				end
			end
			MODE_UNMAP: begin
				rsp_d.slot = SLOT_W'(slot_s4);
				if (free_q[slot_s4] || rel_q[slot_s4])
					rsp_d.status = ST_NOT_USED;
				else
					rel_d[slot_s4] = 1'b1;
			end
			MODE_FLUSH: begin
				free_d = free_q | rel_q;
				rel_d  = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			rel_q  <= '0;
		end else if (adv && v_s4) begin
			free_q <= free_d;
			rel_q  <= rel_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			rsp_q <= rsp_d;
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.slot         = rsp_q.slot;
	assign rsp.mapped_addr  = rsp_q.mapped_addr;
	assign rsp.flush_needed = rsp_q.flush_needed;
	assign rsp.flush_addr   = rsp_q.flush_addr;

endmodule
